// ===== src/bcsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balance controller package
// Shared constants for the two-wheel balance controller: default sizes,
// command characters, mode codes, register indexes and gain presets.
// ----------------------------------------------------------------------------
package bcsd_pkg;

   localparam int DEF_WINDOW    = 20;
   localparam int DEF_FRAC_BITS = 8;

   localparam int POS_LIMIT  = 60000;
   localparam logic [7:0] RAMP_STEPS = 8'd200;

   // Command characters.
   localparam logic [7:0] CMD_FWD   = 8'h66;
   localparam logic [7:0] CMD_BACK  = 8'h62;
   localparam logic [7:0] CMD_LEFT  = 8'h6c;
   localparam logic [7:0] CMD_RIGHT = 8'h72;
   localparam logic [7:0] CMD_STOP  = 8'h73;

   // Motion modes.
   localparam logic [2:0] MODE_FRONT = 3'd0;
   localparam logic [2:0] MODE_BACK  = 3'd1;
   localparam logic [2:0] MODE_LEFT  = 3'd2;
   localparam logic [2:0] MODE_RIGHT = 3'd3;
   localparam logic [2:0] MODE_STOP  = 3'd4;

   // Register indexes.
   localparam logic [1:0] CSR_ANGLE_TARGET = 2'd0;
   localparam logic [1:0] CSR_ANGLE_GAIN   = 2'd1;
   localparam logic [1:0] CSR_RATE_GAIN    = 2'd2;
   localparam logic [1:0] CSR_MAX_SPEED    = 2'd3;

   // Gain presets, 20 fractional bits.
   localparam logic [23:0] PGAIN_SLOW = 24'd10486;
   localparam logic [23:0] PGAIN_TURN = 24'd31457;
   localparam logic [23:0] PGAIN_FAST = 24'd52429;
   localparam logic [23:0] SGAIN_UNIT = 24'd1048576;
   localparam logic [23:0] SGAIN_FAST = 24'd1572864;
   localparam logic [23:0] PGAIN_STEP = 24'd210;
   localparam logic [23:0] SGAIN_STEP = 24'd2621;

   localparam logic signed [15:0] TARGET_FULL = 16'sd10000;
   localparam logic signed [15:0] TARGET_STEP = 16'sd50;
   localparam logic signed [10:0] TURN_OFFSET = 11'sd500;

   localparam int          PERIOD_NUM = 1000000;
   localparam logic [15:0] PERIOD_MAX = 16'hffff;

endpackage
`default_nettype wire

// ===== src/bcsd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balance controller divider
// Unsigned restoring divider that retires two quotient bits per cycle.
// done pulses for one cycle once the quotient is valid.
// ----------------------------------------------------------------------------
module bcsd_div #(
   parameter int DVD_W = 28,
   parameter int DVS_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int STEPS = DVD_W / 2;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;

   always_comb begin
      logic [DVS_W:0]   trial;
      logic [DVS_W:0]   rem;
      logic [DVD_W-1:0] quo;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem     = {1'b0, rem_ff};
      quo     = quo_ff;
      for (int i = 0; i < 2; i++) begin
         trial = {rem[DVS_W-1:0], quo[DVD_W-1]};
         quo   = {quo[DVD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem    = trial - {1'b0, dvs_ff};
            quo[0] = 1'b1;
         end else begin
            rem = trial;
         end
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = rem[DVS_W-1:0];
         quo_in = quo;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/balance_controller_step_drive.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balance controller step drive
// Two-wheel balance loop: speed averaging window, speed filter, position
// integral, PD drive and per-wheel step periods, plus remote commands.
// ----------------------------------------------------------------------------
// A command transaction (req_tuser = 1) updates the motion state and gives its
// result through ST_DONE and the output register. A tick transaction (req_tuser = 0)
// runs four divisions on one shared divider that retires two bits per cycle
// (window mean, speed filter, two step periods) and four multiplies on one
// shared multiplier. The block works on one transaction at a time and takes
// the next one while the last result waits on the output register.
// The averaging window lives in a small memory with a registered read and
// per-entry valid bits, so it reads as zero after reset without a clear pass.
// ----------------------------------------------------------------------------
module balance_controller_step_drive
   import bcsd_pkg::*;
#(
   parameter int WINDOW    = DEF_WINDOW,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tilt_angle [15:0], tilt_rate [35:16], command_char [43:36]
   input  wire logic [47:0] req_tdata,
   // func
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // move_mode [2:0], left_reverse [3], right_forward [4],
   // left_step_period [20:5], right_step_period [36:21]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [23:0] csr_wdata
);

   localparam int F      = FRAC_BITS;
   localparam int G      = 20 - FRAC_BITS;
   localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = 17 + $clog2(WINDOW + 1);
   localparam int SPD_W  = 17 + F;
   localparam int POS_W  = 17 + F;
   localparam int POSX_W = POS_W + 2;
   localparam int NUM_W  = 21 + F;
   localparam int DVD_W  = ((21 + F) / 2) * 2;
   localparam int DVS_W  = 16;
   localparam int MUL_W  = POS_W + 25;
   localparam int ACC_W  = MUL_W + 2;
   localparam int WHL_W  = ACC_W + 1;

   localparam logic signed [POSX_W-1:0] POS_LIM = POSX_W'(longint'(POS_LIMIT) <<< F);
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW - 1);

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_SUM  = 14'b00000000000010,
      ST_MEAN = 14'b00000000000100,
      ST_SMTH = 14'b00000000001000,
      ST_POSN = 14'b00000000010000,
      ST_MA   = 14'b00000000100000,
      ST_MR   = 14'b00000001000000,
      ST_MP   = 14'b00000010000000,
      ST_MS   = 14'b00000100000000,
      ST_DRV  = 14'b00001000000000,
      ST_WHL  = 14'b00010000000000,
      ST_PERL = 14'b00100000000000,
      ST_PERR = 14'b01000000000000,
      ST_DONE = 14'b10000000000000
   } state_type;

   // Wheel value from the drive: truncate toward zero, then saturate.
   function automatic logic signed [15:0] wheel_speed(input logic signed [WHL_W-1:0] w,
                                                      input logic [14:0] lim);
      logic signed [WHL_W-1:0] t;
      logic signed [WHL_W-1:0] l;
      l = WHL_W'($signed({1'b0, lim}));
      if (w < 0) begin
         t = (w + WHL_W'((longint'(1) <<< (2 * F)) - 1)) >>> (2 * F);
      end else begin
         t = w >>> (2 * F);
      end
      if (t > l) begin
         t = l;
      end else if (t < -l) begin
         t = -l;
      end
      return t[15:0];
   endfunction

   function automatic logic [15:0] step_period(input logic signed [15:0] s,
                                               input logic [DVD_W-1:0] q);
      if (s == 16'sd0) begin
         return PERIOD_MAX;
      end else if (q > DVD_W'(PERIOD_MAX)) begin
         return PERIOD_MAX;
      end else begin
         return q[15:0];
      end
   endfunction

   function automatic logic [DVS_W-1:0] speed_mag(input logic signed [15:0] s);
      return (s < 0) ? DVS_W'(-s) : DVS_W'(s);
   endfunction

   state_type state_ff, state_in;

   logic signed [15:0]       at_ff, at_in;
   logic [23:0]              ag_ff, ag_in;
   logic [23:0]              rg_ff, rg_in;
   logic [14:0]              ms_ff, ms_in;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SPD_W-1:0]  smooth_ff, smooth_in;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [15:0]       lspd_ff, lspd_in;
   logic signed [15:0]       rspd_ff, rspd_in;
   logic [23:0]              pg_ff, pg_in;
   logic [23:0]              sg_ff, sg_in;
   logic signed [15:0]       tgt_ff, tgt_in;
   logic signed [10:0]       tl_ff, tl_in;
   logic signed [10:0]       tr_ff, tr_in;
   logic [7:0]               ramp_ff, ramp_in;
   logic [7:0]               last_ff, last_in;
   logic [2:0]               mode_ff, mode_in;
   logic [HEAD_W-1:0]        head_ff, head_in;
   logic [WINDOW-1:0]        vld_ff, vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [15:0]       angle_ff, angle_in;
   logic signed [19:0]       rate_ff, rate_in;
   logic                     cmd_ff, cmd_in;
   logic signed [15:0]       pushed_ff, pushed_in;
   logic                     neg_ff, neg_in;
   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     lrev_ff, lrev_in;
   logic                     rfwd_ff, rfwd_in;
   logic [15:0]              lper_ff, lper_in;
   logic [15:0]              rper_ff, rper_in;
   logic [39:0]              rsp_data_ff, rsp_data_in;

   logic signed [15:0]       win_mem [WINDOW];
   logic signed [15:0]       rd_data_ff;
   logic                     rd_vld_ff;
   logic                     mem_we;

   logic                     div_start;
   logic                     div_done;
   logic [DVD_W-1:0]         div_dvd;
   logic [DVS_W-1:0]         div_dvs;
   logic [DVD_W-1:0]         div_quo;

   logic signed [POS_W-1:0]  mul_a;
   logic signed [24:0]       mul_b;

   always_comb begin
      logic [7:0]              c;
      logic                    fwd;
      logic signed [16:0]      psum;
      logic signed [15:0]      old_val;
      logic signed [15:0]      mean;
      logic signed [SUM_W-1:0] sum_nx;
      logic signed [NUM_W-1:0] num;
      logic signed [POSX_W-1:0] px;
      logic signed [WHL_W-1:0] wl;
      logic signed [WHL_W-1:0] wr;
      logic signed [15:0]      vl;
      logic signed [15:0]      vr;

      state_in     = state_ff;
      at_in        = at_ff;
      ag_in        = ag_ff;
      rg_in        = rg_ff;
      ms_in        = ms_ff;
      sum_in       = sum_ff;
      smooth_in    = smooth_ff;
      pos_in       = pos_ff;
      lspd_in      = lspd_ff;
      rspd_in      = rspd_ff;
      pg_in        = pg_ff;
      sg_in        = sg_ff;
      tgt_in       = tgt_ff;
      tl_in        = tl_ff;
      tr_in        = tr_ff;
      ramp_in      = ramp_ff;
      last_in      = last_ff;
      mode_in      = mode_ff;
      head_in      = head_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      angle_in     = angle_ff;
      rate_in      = rate_ff;
      cmd_in       = cmd_ff;
      pushed_in    = pushed_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      lrev_in      = lrev_ff;
      rfwd_in      = rfwd_ff;
      lper_in      = lper_ff;
      rper_in      = rper_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dvs      = '0;
      mul_a        = '0;
      mul_b        = '0;

      c       = req_tdata[43:36];
      fwd     = (c == CMD_FWD);
      psum    = 17'(lspd_ff) + 17'(rspd_ff);
      old_val = rd_vld_ff ? rd_data_ff : 16'sd0;
      sum_nx  = sum_ff + SUM_W'(pushed_ff) - SUM_W'(old_val);
      mean    = neg_ff ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
      num     = 7 * NUM_W'(smooth_ff) + 3 * (NUM_W'(mean) <<< F) + 5;
      px      = POSX_W'(pos_ff) + POSX_W'(smooth_ff) - (POSX_W'(tgt_ff) <<< F);
      wl      = (WHL_W'(tl_ff) <<< (2 * F)) - WHL_W'(acc_ff);
      wr      = (WHL_W'(tr_ff) <<< (2 * F)) - WHL_W'(acc_ff);
      vl      = wheel_speed(wl, ms_ff);
      vr      = wheel_speed(wr, ms_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               angle_in = $signed(req_tdata[15:0]);
               rate_in  = $signed(req_tdata[35:16]);
               cmd_in   = req_tuser;
               if (req_tuser) begin
                  case (c)
                     CMD_FWD, CMD_BACK: begin
                        mode_in = fwd ? MODE_FRONT : MODE_BACK;
                        if (last_ff == (fwd ? CMD_BACK : CMD_FWD)) begin
                           // Reversal: restart from soft gains and ramp up.
                           pg_in   = PGAIN_SLOW;
                           sg_in   = SGAIN_UNIT;
                           tgt_in  = '0;
                           tl_in   = '0;
                           tr_in   = '0;
                           ramp_in = RAMP_STEPS;
                        end else if (ramp_ff == 8'd0) begin
                           pg_in  = PGAIN_FAST;
                           sg_in  = SGAIN_FAST;
                           tgt_in = fwd ? -TARGET_FULL : TARGET_FULL;
                           tl_in  = '0;
                           tr_in  = '0;
                        end else begin
                           ramp_in = ramp_ff - 8'd1;
                           pg_in   = pg_ff + PGAIN_STEP;
                           sg_in   = sg_ff + SGAIN_STEP;
                           tgt_in  = fwd ? tgt_ff - TARGET_STEP : tgt_ff + TARGET_STEP;
                        end
                     end
                     CMD_LEFT: begin
                        mode_in = MODE_LEFT;
                        pg_in   = PGAIN_TURN;
                        sg_in   = SGAIN_FAST;
                        tgt_in  = '0;
                        tl_in   = -TURN_OFFSET;
                        tr_in   = TURN_OFFSET;
                        ramp_in = '0;
                     end
                     CMD_RIGHT: begin
                        mode_in = MODE_RIGHT;
                        pg_in   = PGAIN_TURN;
                        sg_in   = SGAIN_FAST;
                        tgt_in  = '0;
                        tl_in   = TURN_OFFSET;
                        tr_in   = -TURN_OFFSET;
                        ramp_in = '0;
                     end
                     CMD_STOP: begin
                        mode_in = MODE_STOP;
                        pg_in   = PGAIN_SLOW;
                        sg_in   = SGAIN_UNIT;
                        tgt_in  = '0;
                        tl_in   = '0;
                        tr_in   = '0;
                        ramp_in = '0;
                     end
                     default: begin
                     end
                  endcase
                  last_in  = c;
                  state_in = ST_DONE;
               end else begin
                  // Mean of the two wheels, rounded toward zero.
                  pushed_in = 16'((psum + $signed({16'b0, psum[16]})) >>> 1);
                  state_in  = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            sum_in          = sum_nx;
            mem_we          = 1'b1;
            vld_in[head_ff] = 1'b1;
            head_in         = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
            neg_in          = sum_nx < 0;
            div_start       = 1'b1;
            div_dvd         = DVD_W'((sum_nx < 0) ? -sum_nx : sum_nx);
            div_dvs         = DVS_W'(WINDOW);
            state_in        = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               // Floor division by ten through the magnitude.
               neg_in    = num < 0;
               div_start = 1'b1;
               div_dvd   = DVD_W'((num < 0) ? 9 - num : num);
               div_dvs   = DVS_W'(10);
               state_in  = ST_SMTH;
            end
         end
         ST_SMTH: begin
            if (div_done) begin
               smooth_in = neg_ff ? -$signed(div_quo[SPD_W-1:0]) : $signed(div_quo[SPD_W-1:0]);
               state_in  = ST_POSN;
            end
         end
         ST_POSN: begin
            if (px > POS_LIM) begin
               pos_in = POS_W'(POS_LIM);
            end else if (px < -POS_LIM) begin
               pos_in = POS_W'(-POS_LIM);
            end else begin
               pos_in = POS_W'(px);
            end
            state_in = ST_MA;
         end
         ST_MA: begin
            mul_a    = POS_W'(at_ff) - POS_W'(angle_ff);
            mul_b    = $signed({1'b0, ag_ff});
            prod_in  = MUL_W'(mul_a) * MUL_W'(mul_b);
            acc_in   = '0;
            state_in = ST_MR;
         end
         ST_MR: begin
            mul_a    = POS_W'(rate_ff);
            mul_b    = $signed({1'b0, rg_ff});
            prod_in  = MUL_W'(mul_a) * MUL_W'(mul_b);
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_MP;
         end
         ST_MP: begin
            mul_a    = pos_ff;
            mul_b    = $signed({1'b0, pg_ff});
            prod_in  = MUL_W'(mul_a) * MUL_W'(mul_b);
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_MS;
         end
         ST_MS: begin
            mul_a    = POS_W'(smooth_ff);
            mul_b    = $signed({1'b0, sg_ff});
            prod_in  = MUL_W'(mul_a) * MUL_W'(mul_b);
            acc_in   = acc_ff - ACC_W'(prod_ff >>> G);
            state_in = ST_DRV;
         end
         ST_DRV: begin
            acc_in   = acc_ff - ACC_W'(prod_ff >>> G);
            state_in = ST_WHL;
         end
         ST_WHL: begin
            lspd_in   = vl;
            rspd_in   = vr;
            lrev_in   = !(vl > 0);
            rfwd_in   = vr > 0;
            div_start = 1'b1;
            div_dvd   = DVD_W'(PERIOD_NUM);
            div_dvs   = speed_mag(vl);
            state_in  = ST_PERL;
         end
         ST_PERL: begin
            if (div_done) begin
               lper_in   = step_period(lspd_ff, div_quo);
               div_start = 1'b1;
               div_dvd   = DVD_W'(PERIOD_NUM);
               div_dvs   = speed_mag(rspd_ff);
               state_in  = ST_PERR;
            end
         end
         ST_PERR: begin
            if (div_done) begin
               rper_in  = step_period(rspd_ff, div_quo);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (cmd_ff) begin
                  rsp_data_in = {37'b0, mode_ff};
               end else begin
                  rsp_data_in = {3'b0, rper_ff, lper_ff, rfwd_ff, lrev_ff, mode_ff};
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_addr)
            CSR_ANGLE_TARGET: at_in = $signed(csr_wdata[15:0]);
            CSR_ANGLE_GAIN:   ag_in = csr_wdata;
            CSR_RATE_GAIN:    rg_in = csr_wdata;
            CSR_MAX_SPEED:    ms_in = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         at_ff        <= '0;
         ag_ff        <= 24'd76800;
         rg_ff        <= '0;
         ms_ff        <= 15'd5500;
         sum_ff       <= '0;
         smooth_ff    <= '0;
         pos_ff       <= '0;
         lspd_ff      <= '0;
         rspd_ff      <= '0;
         pg_ff        <= PGAIN_SLOW;
         sg_ff        <= SGAIN_UNIT;
         tgt_ff       <= '0;
         tl_ff        <= '0;
         tr_ff        <= '0;
         ramp_ff      <= '0;
         last_ff      <= '0;
         mode_ff      <= MODE_STOP;
         head_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         at_ff        <= at_in;
         ag_ff        <= ag_in;
         rg_ff        <= rg_in;
         ms_ff        <= ms_in;
         sum_ff       <= sum_in;
         smooth_ff    <= smooth_in;
         pos_ff       <= pos_in;
         lspd_ff      <= lspd_in;
         rspd_ff      <= rspd_in;
         pg_ff        <= pg_in;
         sg_ff        <= sg_in;
         tgt_ff       <= tgt_in;
         tl_ff        <= tl_in;
         tr_ff        <= tr_in;
         ramp_ff      <= ramp_in;
         last_ff      <= last_in;
         mode_ff      <= mode_in;
         head_ff      <= head_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      rate_ff     <= rate_in;
      cmd_ff      <= cmd_in;
      pushed_ff   <= pushed_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      lrev_ff     <= lrev_in;
      rfwd_ff     <= rfwd_in;
      lper_ff     <= lper_in;
      rper_ff     <= rper_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Window memory: the entry at the head is read every cycle and is
   // overwritten in the following cycle in the update step.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[head_ff] <= pushed_ff;
      end
      rd_data_ff <= win_mem[head_ff];
      rd_vld_ff  <= vld_ff[head_ff];
   end

   bcsd_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/bcsd_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balance controller port checker
// Watches the result channel of the top level and flags illegal results.
// ----------------------------------------------------------------------------
module bcsd_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // A pending result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // No result comes out right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // The mode field carries only defined modes.
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd5 && rsp_tdata[2:0] != 3'd6 &&
                     rsp_tdata[2:0] != 3'd7)
      else $error("undefined mode code in result");

   // A zero left period marks a command result, so the rest is zero too.
   a_cmd_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20:5] == 16'd0 |->
         rsp_tdata[36:21] == 16'd0 && rsp_tdata[4:3] == 2'b00)
      else $error("command result with nonzero drive fields");

endmodule

bind balance_controller_step_drive bcsd_check u_bcsd_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== sim/tb_balance_controller_step_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balance controller step drive testbench
// Drives tick and command transactions into the controller, predicts every
// result with a fixed-point model of the balance loop kept in the bench, and
// compares each result field by field. Runs several register settings with
// random idling on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_balance_controller_step_drive;
   import bcsd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 80;
   localparam int ITEMS_PER_PHASE = 400;

   typedef struct packed {
      logic [2:0]  mode;
      logic        left_rev;
      logic        right_fwd;
      logic [15:0] left_period;
      logic [15:0] right_period;
   } wheel_out_t;

   typedef struct {
      logic        is_cmd;
      logic [15:0] angle;
      logic [19:0] rate;
      logic [7:0]  cmd;
      logic        typed;
      wheel_out_t  result;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_ANGLE_TARGET;
   logic [23:0] csr_wdata = '0;

   balance_controller_step_drive i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the controller state and registers.
   logic signed [15:0] cfg_angle_target;
   logic [23:0]        cfg_angle_gain;
   logic [23:0]        cfg_rate_gain;
   logic [14:0]        cfg_max_speed;
   longint             speed_hist [DEF_WINDOW];
   int                 hist_head;
   longint             hist_sum;
   longint             speed_filt;
   longint             pos_accum;
   longint             left_spd;
   longint             right_spd;
   logic [23:0]        pos_gain;
   logic [23:0]        spd_gain;
   logic signed [15:0] spd_target;
   longint             left_turn;
   longint             right_turn;
   logic [7:0]         ramp_left;
   logic [7:0]         prev_cmd;
   logic [2:0]         cur_mode;

   wheel_out_t expected_q [$];
   int  error_count = 0;
   int  ticks_sent = 0;
   int  cmds_sent = 0;
   int  results_seen = 0;
   bit  idle_on = 1'b1;
   bit  long_hold = 1'b0;
   int  quiet_cycles = 0;

   function automatic void reset_model();
      cfg_angle_target = 16'sd0;
      cfg_angle_gain   = 24'd76800;
      cfg_rate_gain    = 24'd0;
      cfg_max_speed    = 15'd5500;
      foreach (speed_hist[i]) speed_hist[i] = 0;
      hist_head  = 0;
      hist_sum   = 0;
      speed_filt = 0;
      pos_accum  = 0;
      left_spd   = 0;
      right_spd  = 0;
      ramp_left  = 8'd0;
      prev_cmd   = 8'd0;
      cur_mode   = MODE_STOP;
      pos_gain   = PGAIN_SLOW;
      spd_gain   = SGAIN_UNIT;
      spd_target = 16'sd0;
      left_turn  = 0;
      right_turn = 0;
   endfunction

   function automatic longint trunc_shift16(longint v);
      return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
   endfunction

   function automatic logic [15:0] period_of(longint s);
      longint mag;
      longint q;
      mag = (s < 0) ? -s : s;
      if (mag == 0) return PERIOD_MAX;
      q = PERIOD_NUM / mag;
      return (q > 65535) ? PERIOD_MAX : q[15:0];
   endfunction

   function automatic longint clamp_speed(longint v);
      longint lim;
      lim = longint'(cfg_max_speed);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic void set_motion(logic [2:0] m, logic [23:0] pg, logic [23:0] sg,
                                      logic signed [15:0] tgt, longint tl, longint tr);
      cur_mode   = m;
      pos_gain   = pg;
      spd_gain   = sg;
      spd_target = tgt;
      left_turn  = tl;
      right_turn = tr;
   endfunction

   function automatic void drive_command(logic [2:0] m, logic [7:0] opposite, bit forward);
      cur_mode = m;
      if (prev_cmd == opposite) begin
         set_motion(m, PGAIN_SLOW, SGAIN_UNIT, 16'sd0, 0, 0);
         ramp_left = RAMP_STEPS;
      end else if (ramp_left == 8'd0) begin
         set_motion(m, PGAIN_FAST, SGAIN_FAST, forward ? -TARGET_FULL : TARGET_FULL, 0, 0);
      end else begin
         ramp_left  = ramp_left - 8'd1;
         pos_gain   = pos_gain + PGAIN_STEP;
         spd_gain   = spd_gain + SGAIN_STEP;
         spd_target = forward ? spd_target - TARGET_STEP : spd_target + TARGET_STEP;
      end
   endfunction

   function automatic wheel_out_t apply_command(logic [7:0] c);
      wheel_out_t r;
      case (c)
         CMD_FWD:   drive_command(MODE_FRONT, CMD_BACK, 1'b1);
         CMD_BACK:  drive_command(MODE_BACK, CMD_FWD, 1'b0);
         CMD_LEFT: begin
            set_motion(MODE_LEFT, PGAIN_TURN, SGAIN_FAST, 16'sd0, -500, 500);
            ramp_left = 8'd0;
         end
         CMD_RIGHT: begin
            set_motion(MODE_RIGHT, PGAIN_TURN, SGAIN_FAST, 16'sd0, 500, -500);
            ramp_left = 8'd0;
         end
         CMD_STOP: begin
            set_motion(MODE_STOP, PGAIN_SLOW, SGAIN_UNIT, 16'sd0, 0, 0);
            ramp_left = 8'd0;
         end
         default: ;
      endcase
      prev_cmd = c;
      r = '0;
      r.mode = cur_mode;
      return r;
   endfunction

   function automatic wheel_out_t balance_tick(logic signed [15:0] ang, logic signed [19:0] rt);
      wheel_out_t r;
      longint pushed, mean, num, drv, vl, vr, lim;
      lim = longint'(POS_LIMIT) * 256;
      pushed = (left_spd + right_spd) / 2;
      hist_sum = hist_sum + pushed - speed_hist[hist_head];
      speed_hist[hist_head] = pushed;
      hist_head = (hist_head + 1) % DEF_WINDOW;
      mean = hist_sum / DEF_WINDOW;
      num = 7 * speed_filt + 3 * mean * 256 + 5;
      speed_filt = (num >= 0) ? num / 10 : -((-num + 9) / 10);
      pos_accum = pos_accum + speed_filt - longint'(spd_target) * 256;
      if (pos_accum < -lim) pos_accum = -lim;
      else if (pos_accum > lim) pos_accum = lim;
      drv = longint'(cfg_angle_gain) * (longint'(cfg_angle_target) - longint'(ang))
          + longint'(cfg_rate_gain) * longint'(rt)
          - ((pos_accum * longint'(pos_gain)) >>> 12)
          - ((speed_filt * longint'(spd_gain)) >>> 12);
      vl = clamp_speed(trunc_shift16(left_turn * 65536 - drv));
      vr = clamp_speed(trunc_shift16(right_turn * 65536 - drv));
      left_spd  = vl;
      right_spd = vr;
      r.mode         = cur_mode;
      r.left_rev     = (vl > 0) ? 1'b0 : 1'b1;
      r.right_fwd    = (vr > 0) ? 1'b1 : 1'b0;
      r.left_period  = period_of(vl);
      r.right_period = period_of(vr);
      return r;
   endfunction

   // Offers one transaction; entered and left at a falling edge.
   task automatic send_item(stim_row_t row);
      wheel_out_t predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= row.is_cmd;
      req_tdata  <= {4'b0, row.cmd, row.rate, row.angle};
      do @(posedge clock); while (!req_tready);
      if (row.is_cmd) begin
         predicted = apply_command(row.cmd);
         cmds_sent++;
      end else begin
         predicted = balance_tick(row.angle, row.rate);
         ticks_sent++;
      end
      expected_q.push_back(row.typed ? row.result : predicted);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(logic [23:0] at, logic [23:0] ag, logic [23:0] rg,
                             logic [23:0] ms);
      logic [23:0] vals [4];
      vals = '{at, ag, rg, ms};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= i[1:0];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cfg_angle_target = at[15:0];
      cfg_angle_gain   = ag;
      cfg_rate_gain    = rg;
      cfg_max_speed    = ms[14:0];
   endtask

   function automatic stim_row_t tick_row(logic [15:0] a, logic [19:0] r);
      stim_row_t s;
      s.is_cmd = 1'b0;
      s.angle  = a;
      s.rate   = r;
      s.cmd    = 8'($urandom);
      s.typed  = 1'b0;
      s.result = '0;
      return s;
   endfunction

   function automatic stim_row_t cmd_row(logic [7:0] c);
      stim_row_t s;
      s = tick_row(16'($urandom), 20'($urandom));
      s.is_cmd = 1'b1;
      s.cmd    = c;
      return s;
   endfunction

   function automatic stim_row_t typed(stim_row_t s, wheel_out_t r);
      s.typed  = 1'b1;
      s.result = r;
      return s;
   endfunction

   // Mostly small angles and rates so the loop stays in range; runs of
   // forward or back commands walk through reversals and the ramp.
   logic [7:0] favored_dir = CMD_FWD;
   function automatic stim_row_t random_row();
      logic [15:0] a;
      logic [19:0] r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048) - 1024);
         r = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4096) - 2048);
         return tick_row(a, r);
      end
      if ($urandom_range(0, 49) == 0)
         favored_dir = (favored_dir == CMD_FWD) ? CMD_BACK : CMD_FWD;
      if (pick < 90) return cmd_row(favored_dir);
      case ($urandom_range(0, 4))
         0: return cmd_row(CMD_LEFT);
         1: return cmd_row(CMD_RIGHT);
         2: return cmd_row(CMD_STOP);
         3: return cmd_row(favored_dir == CMD_FWD ? CMD_BACK : CMD_FWD);
         default: return cmd_row(8'($urandom));
      endcase
   endfunction

   // Output side: random stalls, plus one long hold on request.
   always begin
      @(negedge clock);
      if (long_hold) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES - 1) @(negedge clock);
         long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      wheel_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[2:0] !== want.mode) begin
               $error("move_mode: expected %0d, got %0d", want.mode, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[3] !== want.left_rev) begin
               $error("left_reverse: expected %0d, got %0d", want.left_rev, rsp_tdata[3]);
               error_count++;
            end
            if (rsp_tdata[4] !== want.right_fwd) begin
               $error("right_forward: expected %0d, got %0d", want.right_fwd, rsp_tdata[4]);
               error_count++;
            end
            if (rsp_tdata[20:5] !== want.left_period) begin
               $error("left_step_period: expected %0d, got %0d",
                      want.left_period, rsp_tdata[20:5]);
               error_count++;
            end
            if (rsp_tdata[36:21] !== want.right_period) begin
               $error("right_step_period: expected %0d, got %0d",
                      want.right_period, rsp_tdata[36:21]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_balance_controller_step_drive: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_t  directed [$];
      wheel_out_t r;
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, defaults after reset.
      r = '{MODE_STOP, 1'b1, 1'b0, PERIOD_MAX, PERIOD_MAX};
      directed.push_back(typed(tick_row(16'h0000, 20'h00000), r));
      r = '{MODE_STOP, 1'b0, 1'b1, 16'd181, 16'd181};
      directed.push_back(typed(tick_row(16'h7fff, 20'h00000), r));
      r = '{MODE_STOP, 1'b1, 1'b0, 16'd181, 16'd181};
      directed.push_back(typed(tick_row(16'h8000, 20'h00000), r));
      directed.push_back(tick_row(16'h0000, 20'h7ffff));
      directed.push_back(tick_row(16'hffff, 20'h80000));
      r = '0;
      r.mode = MODE_STOP;
      directed.push_back(typed(cmd_row(8'h78), r));
      directed.push_back(typed(cmd_row(CMD_STOP), r));
      r.mode = MODE_FRONT;
      directed.push_back(typed(cmd_row(CMD_FWD), r));
      directed.push_back(tick_row(16'h0010, 20'h00020));
      r.mode = MODE_BACK;
      directed.push_back(typed(cmd_row(CMD_BACK), r));
      directed.push_back(typed(cmd_row(CMD_BACK), r));
      directed.push_back(typed(cmd_row(CMD_BACK), r));
      directed.push_back(tick_row(16'hfff0, 20'hfffe0));
      directed.push_back(cmd_row(CMD_FWD));
      directed.push_back(cmd_row(CMD_FWD));
      directed.push_back(tick_row(16'h0100, 20'h00000));
      r.mode = MODE_LEFT;
      directed.push_back(typed(cmd_row(CMD_LEFT), r));
      directed.push_back(tick_row(16'h0000, 20'h00000));
      r.mode = MODE_RIGHT;
      directed.push_back(typed(cmd_row(CMD_RIGHT), r));
      directed.push_back(tick_row(16'h0000, 20'h00000));
      directed.push_back(cmd_row(8'hff));
      directed.push_back(tick_row(16'hff00, 20'h00100));
      foreach (directed[i]) send_item(directed[i]);

      for (int phase = 0; phase < 5; phase++) begin
         drain_and_settle();
         case (phase)
            0: write_regs(24'h008000, 24'hffffff, 24'h000000, 24'h000000);
            1: write_regs(24'h007fff, 24'h000000, 24'hffffff, 24'h007fff);
            2: write_regs(24'($urandom_range(0, 512)), 24'($urandom_range(20000, 120000)),
                          24'($urandom_range(0, 4096)), 24'($urandom_range(100, 30000)));
            3: write_regs(24'h00ff80, 24'd76800, 24'd256, 24'd5500);
            default: begin
               write_regs(24'h000000, 24'd76800, 24'd0, 24'd5500);
               idle_on = 1'b0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 100) begin
               // Keep offering while the output is held back.
               req_tvalid <= 1'b0;
               idle_on = 1'b0;
               long_hold = 1'b1;
               @(negedge clock);
            end
            if (phase == 1 && n == 130) idle_on = 1'b1;
            if (phase == 2 && n == 200) drain_and_settle();
            send_item(random_row());
         end
      end

      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d ticks and %0d commands, %0d results, over six register settings",
               ticks_sent, cmds_sent, results_seen);
      $display("including a long output hold and a full drain mid-run");
      if (error_count == 0)
         $display("tb_balance_controller_step_drive: done, clean");
      else
         $display("tb_balance_controller_step_drive: done, errors");
      $finish;
   end

endmodule

// ===== balance_controller_step_drive.f =====
src/bcsd_pkg.sv
src/bcsd_div.sv
src/balance_controller_step_drive.sv
src/bcsd_check.sv
sim/tb_balance_controller_step_drive.sv
